>>> sv/eac_pkg.sv
`timescale 1ns / 1ps
// Package for the environment alarm controller: alarm level codes, request and
// result payload types, configuration register indexes and fixed widths. No dependencies.
package eac_pkg;

	typedef enum logic [1:0] {
		LVL_SAFE = 2'd0,
		LVL_WARN = 2'd1,
		LVL_CRIT = 2'd2
	} level_t;

	localparam logic MODE_EVAL = 1'b0;
	localparam logic MODE_LED  = 1'b1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_TEMP_SAFE_MAX    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_WARN_MAX    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HUM_SAFE_MIN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HUM_SAFE_MAX     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_CRIT_BELOW = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_WARN_MAX   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SMOKE_WARN_MIN   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SMOKE_CRIT_ABOVE = 3'd7;

	localparam logic [6:0] DUTY_FULL = 7'd100;
	localparam logic [6:0] DUTY_OFF  = 7'd0;

	localparam logic [1:0] FAN_STOP   = 2'd0;
	localparam logic [1:0] FAN_MEDIUM = 2'd1;
	localparam logic [1:0] FAN_HIGH   = 2'd2;

	typedef struct packed {
		logic        mode;
		logic [7:0]  temperature;
		logic [7:0]  humidity;
		logic [11:0] light_level;
		logic [15:0] smoke_ppm;
	} req_t;

	typedef struct packed {
		logic [1:0] alarm_level;
		logic       buzzer_on;
		logic [6:0] red_duty;
		logic [6:0] green_duty;
		logic [1:0] fan_level;
	} rsp_t;

endpackage

>>> sv/eac_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the environment alarm controller.
// Depends on eac_pkg for the request and result payload types.
interface eac_req_if;
	logic          valid;
	logic          ready;
	eac_pkg::req_t payload;
	modport source (output valid, payload, input ready);
	modport sink (input valid, payload, output ready);
endinterface

interface eac_rsp_if;
	logic          valid;
	logic          ready;
	eac_pkg::rsp_t payload;
	modport source (output valid, payload, input ready);
	modport sink (input valid, payload, output ready);
endinterface

>>> sv/environment_alarm_controller.sv
`timescale 1ns / 1ps
// Top level of the environment alarm controller: threshold registers, alarm state,
// buzzer and LED breathing logic. Depends on eac_pkg and the channels in eac_if.sv.

// The controller takes one request per clock and returns exactly one result per
// request, in order. An evaluate request (mode 0) sorts temperature, humidity, light
// and smoke into safe, warning or critical, latches the temperature flags that set
// the fan level and steps the buzzer; an LED tick (mode 1) steps the red and green
// breathing duties from the current level. Each result reports the state left
// behind by its request. A request is captured in an input register and resolved
// against the alarm state into the result register, the alarm, buzzer and brightness
// state being updated in the same cycle, so a new request is taken while the last one
// resolves; the rate of one request per clock holds while the result side is ready.
// While a finished result waits to be taken, the input register still takes one more
// request, then holds it and stalls the request side until the result leaves. Write
// the threshold registers only while no request is in flight.
module environment_alarm_controller #(
	parameter int BEEP_TOGGLE_TICKS = 10,
	parameter int LED_MIN           = 10,
	parameter int LED_MAX           = 100,
	parameter int STEP_WARN         = 5,
	parameter int STEP_CRIT         = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [eac_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [eac_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	eac_req_if.sink                         req,
	eac_rsp_if.source                       rsp
);

	// Threshold registers
	logic [7:0]  temp_safe_max_q, temp_warn_max_q, hum_safe_min_q, hum_safe_max_q;
	logic [11:0] light_crit_below_q, light_warn_max_q;
	logic [15:0] smoke_warn_min_q, smoke_crit_above_q;

	// Alarm and LED state
	eac_pkg::level_t level_q, level_d;
	logic            buzz_q, buzz_d;
	logic [3:0]      buzz_count_q, buzz_count_d;
	logic [6:0]      brightness_q, brightness_d;
	logic            rising_q, rising_d;
	logic            temp_warn_q, temp_warn_d;
	logic            temp_crit_q, temp_crit_d;
	logic [6:0]      red_q, red_d;
	logic [6:0]      green_q, green_d;

	// Input stage and result register
	logic          valid_s1;
	eac_pkg::req_t req_s1;
	logic          rsp_valid_q;
	eac_pkg::rsp_t rsp_q;
	logic          advance;

	// Combinational helpers
	logic       lvl_crit, lvl_warn;
	logic [3:0] cnt_inc;
	logic [7:0] step;
	logic [7:0] up_sum, down_floor;

	// Resolve the input stage whenever the result register is free or being emptied.
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	// Configuration writes; all indexes of the 3-bit field are defined registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_safe_max_q    <= 8'd27;
			temp_warn_max_q    <= 8'd35;
			hum_safe_min_q     <= 8'd30;
			hum_safe_max_q     <= 8'd70;
			light_crit_below_q <= 12'd2000;
			light_warn_max_q   <= 12'd3000;
			smoke_warn_min_q   <= 16'd300;
			smoke_crit_above_q <= 16'd600;
		end else if (cfg_we) begin
			case (cfg_idx)
				eac_pkg::REG_TEMP_SAFE_MAX:    temp_safe_max_q    <= cfg_wdata[7:0];
				eac_pkg::REG_TEMP_WARN_MAX:    temp_warn_max_q    <= cfg_wdata[7:0];
				eac_pkg::REG_HUM_SAFE_MIN:     hum_safe_min_q     <= cfg_wdata[7:0];
				eac_pkg::REG_HUM_SAFE_MAX:     hum_safe_max_q     <= cfg_wdata[7:0];
				eac_pkg::REG_LIGHT_CRIT_BELOW: light_crit_below_q <= cfg_wdata[11:0];
				eac_pkg::REG_LIGHT_WARN_MAX:   light_warn_max_q   <= cfg_wdata[11:0];
				eac_pkg::REG_SMOKE_WARN_MIN:   smoke_warn_min_q   <= cfg_wdata;
				eac_pkg::REG_SMOKE_CRIT_ABOVE: smoke_crit_above_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input register: hold while the result side stalls, load on every accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.payload;
		end
	end

	// Next state for the request held in the input stage.
	always_comb begin
		level_d      = level_q;
		buzz_d       = buzz_q;
		buzz_count_d = buzz_count_q;
		brightness_d = brightness_q;
		rising_d     = rising_q;
		temp_warn_d  = temp_warn_q;
		temp_crit_d  = temp_crit_q;
		red_d        = red_q;
		green_d      = green_q;

		// Classification: critical wins over warning, both applied literally.
		lvl_crit = (req_s1.temperature > temp_warn_max_q)
			|| (req_s1.humidity > hum_safe_max_q)
			|| (req_s1.light_level < light_crit_below_q)
			|| (req_s1.smoke_ppm > smoke_crit_above_q);
		lvl_warn = ((req_s1.temperature > temp_safe_max_q)
				&& (req_s1.temperature <= temp_warn_max_q))
			|| (req_s1.humidity < hum_safe_min_q)
			|| ((req_s1.light_level >= light_crit_below_q)
				&& (req_s1.light_level <= light_warn_max_q))
			|| ((req_s1.smoke_ppm >= smoke_warn_min_q)
				&& (req_s1.smoke_ppm <= smoke_crit_above_q));

		cnt_inc = buzz_count_q + 4'd1;

		// Breathing step for the current level; safe and unused codes do not step.
		step = (level_q == eac_pkg::LVL_CRIT) ? 8'(STEP_CRIT) : 8'(STEP_WARN);
		up_sum     = {1'b0, brightness_q} + step;
		down_floor = 8'(LED_MIN) + step;

		if (req_s1.mode == eac_pkg::MODE_EVAL) begin
			temp_crit_d = req_s1.temperature > temp_warn_max_q;
			temp_warn_d = !temp_crit_d && (req_s1.temperature > temp_safe_max_q);

			if (lvl_crit) begin
				level_d      = eac_pkg::LVL_CRIT;
				buzz_d       = 1'b1;
				buzz_count_d = 4'd0;
			end else if (lvl_warn) begin
				level_d = eac_pkg::LVL_WARN;
				// Start the beep from silence, then toggle every BEEP_TOGGLE_TICKS evaluations.
				if (!buzz_q && buzz_count_q == 4'd0) begin
					buzz_d = 1'b1;
				end
				if (cnt_inc >= 4'(BEEP_TOGGLE_TICKS)) begin
					buzz_count_d = 4'd0;
					buzz_d       = !buzz_d;
				end else begin
					buzz_count_d = cnt_inc;
				end
			end else begin
				level_d      = eac_pkg::LVL_SAFE;
				buzz_d       = 1'b0;
				buzz_count_d = 4'd0;
			end
		end else begin
			case (level_q)
				eac_pkg::LVL_SAFE: begin
					red_d        = eac_pkg::DUTY_OFF;
					green_d      = eac_pkg::DUTY_FULL;
					brightness_d = 7'(LED_MIN);
					rising_d     = 1'b1;
				end
				eac_pkg::LVL_WARN, eac_pkg::LVL_CRIT: begin
					// Bounce between the limits, clamping at each turn.
					if (rising_q) begin
						if (up_sum >= 8'(LED_MAX)) begin
							brightness_d = 7'(LED_MAX);
							rising_d     = 1'b0;
						end else begin
							brightness_d = up_sum[6:0];
						end
					end else begin
						if ({1'b0, brightness_q} <= down_floor) begin
							brightness_d = 7'(LED_MIN);
							rising_d     = 1'b1;
						end else begin
							brightness_d = brightness_q - step[6:0];
						end
					end
					red_d   = brightness_d;
					green_d = (level_q == eac_pkg::LVL_WARN) ? brightness_d : eac_pkg::DUTY_OFF;
				end
				default: begin
					red_d   = eac_pkg::DUTY_OFF;
					green_d = eac_pkg::DUTY_OFF;
				end
			endcase
		end
	end

	// Commit the state when the request leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q      <= eac_pkg::LVL_SAFE;
			buzz_q       <= 1'b0;
			buzz_count_q <= 4'd0;
			brightness_q <= 7'(LED_MIN);
			rising_q     <= 1'b1;
			temp_warn_q  <= 1'b0;
			temp_crit_q  <= 1'b0;
			red_q        <= eac_pkg::DUTY_OFF;
			green_q      <= eac_pkg::DUTY_FULL;
		end else if (advance) begin
			level_q      <= level_d;
			buzz_q       <= buzz_d;
			buzz_count_q <= buzz_count_d;
			brightness_q <= brightness_d;
			rising_q     <= rising_d;
			temp_warn_q  <= temp_warn_d;
			temp_crit_q  <= temp_crit_d;
			red_q        <= red_d;
			green_q      <= green_d;
		end
	end

	// Result register: snapshot the state left by the request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q.alarm_level <= level_d;
			rsp_q.buzzer_on   <= buzz_d;
			rsp_q.red_duty    <= red_d;
			rsp_q.green_duty  <= green_d;
			rsp_q.fan_level   <= temp_crit_d ? eac_pkg::FAN_HIGH
				: (temp_warn_d ? eac_pkg::FAN_MEDIUM : eac_pkg::FAN_STOP);
		end
	end

	// The beep counter wraps before reaching the toggle count.
	a_buzz_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		buzz_count_q < 4'(BEEP_TOGGLE_TICKS))
		else $error("buzzer counter reached toggle count");

	// A critical result always sounds the buzzer; a safe one never does.
	a_buzz_crit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.alarm_level == eac_pkg::LVL_CRIT |-> rsp_q.buzzer_on)
		else $error("critical result without buzzer");

	a_buzz_safe: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.alarm_level == eac_pkg::LVL_SAFE |-> !rsp_q.buzzer_on)
		else $error("safe result with buzzer on");

	// High fan comes only from an over-temperature evaluation, which is critical.
	a_fan_high_crit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.fan_level == eac_pkg::FAN_HIGH
		|-> rsp_q.alarm_level == eac_pkg::LVL_CRIT)
		else $error("high fan without critical level");

	// A request stalled in the input stage stays there.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("stalled request dropped from input stage");

endmodule

>>> sim/alarm_status_checker.sv
`timescale 1ns / 1ps
// Checker for the environment alarm controller: watches the threshold write port and both
// channels, predicts each result and compares it field by field. Depends on eac_pkg, eac_if.sv.
module alarm_status_checker #(
	parameter int BEEP_TOGGLE_TICKS = 10,
	parameter int LED_MIN           = 10,
	parameter int LED_MAX           = 100,
	parameter int STEP_WARN         = 5,
	parameter int STEP_CRIT         = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [eac_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [eac_pkg::CFG_DATA_W-1:0] cfg_wdata,
	eac_req_if                             req_ch,
	eac_rsp_if                             rsp_ch,
	output int                             mismatches,
	output int                             pending
);
	import eac_pkg::*;

	// Threshold copy
	logic [7:0]  th_temp_safe, th_temp_warn, th_hum_min, th_hum_max;
	logic [11:0] th_light_crit, th_light_warn;
	logic [15:0] th_smoke_warn, th_smoke_crit;

	// Alarm state copy
	level_t      alarm_lvl;
	logic        buzz;
	logic [3:0]  beep_cnt;
	logic [6:0]  bright;
	logic        rising;
	logic        t_warn, t_crit;
	logic [6:0]  red, green;

	rsp_t        expected_status[$];
	rsp_t        want;

	// Step the breathing brightness, bouncing between the limits.
	task automatic breathe(input int stp);
		if (rising) begin
			if (int'(bright) + stp >= LED_MAX) begin
				bright = 7'(LED_MAX);
				rising = 1'b0;
			end else begin
				bright = 7'(int'(bright) + stp);
			end
		end else begin
			if (int'(bright) <= LED_MIN + stp) begin
				bright = 7'(LED_MIN);
				rising = 1'b1;
			end else begin
				bright = 7'(int'(bright) - stp);
			end
		end
	endtask

	// Apply one request to the alarm state.
	task automatic update_alarm_state(input req_t r);
		level_t lvl;
		if (r.mode == MODE_EVAL) begin
			t_crit = r.temperature > th_temp_warn;
			t_warn = !t_crit && (r.temperature > th_temp_safe);
			if (r.temperature > th_temp_warn || r.humidity > th_hum_max ||
			    r.light_level < th_light_crit || r.smoke_ppm > th_smoke_crit) begin
				lvl = LVL_CRIT;
			end else if ((r.temperature > th_temp_safe && r.temperature <= th_temp_warn) ||
			             r.humidity < th_hum_min ||
			             (r.light_level >= th_light_crit && r.light_level <= th_light_warn) ||
			             (r.smoke_ppm >= th_smoke_warn && r.smoke_ppm <= th_smoke_crit)) begin
				lvl = LVL_WARN;
			end else begin
				lvl = LVL_SAFE;
			end
			alarm_lvl = lvl;
			case (lvl)
				LVL_SAFE: buzz = 1'b0;
				LVL_WARN: if (!buzz && beep_cnt == 4'd0) buzz = 1'b1;
				default:  buzz = 1'b1;
			endcase
			if (lvl != LVL_WARN) begin
				beep_cnt = 4'd0;
			end else begin
				beep_cnt = beep_cnt + 4'd1;
				if (int'(beep_cnt) >= BEEP_TOGGLE_TICKS) begin
					beep_cnt = 4'd0;
					buzz = ~buzz;
				end
			end
		end else begin
			case (alarm_lvl)
				LVL_SAFE: begin
					red = DUTY_OFF;
					green = DUTY_FULL;
					bright = 7'(LED_MIN);
					rising = 1'b1;
				end
				LVL_WARN: begin
					breathe(STEP_WARN);
					red = bright;
					green = bright;
				end
				LVL_CRIT: begin
					breathe(STEP_CRIT);
					red = bright;
					green = DUTY_OFF;
				end
				default: begin
					red = DUTY_OFF;
					green = DUTY_OFF;
				end
			endcase
		end
	endtask

	task automatic check_field(input string name, input logic [6:0] exp_v, input logic [6:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, got_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			th_temp_safe = 8'd27;
			th_temp_warn = 8'd35;
			th_hum_min = 8'd30;
			th_hum_max = 8'd70;
			th_light_crit = 12'd2000;
			th_light_warn = 12'd3000;
			th_smoke_warn = 16'd300;
			th_smoke_crit = 16'd600;
			alarm_lvl = LVL_SAFE;
			buzz = 1'b0;
			beep_cnt = 4'd0;
			bright = 7'(LED_MIN);
			rising = 1'b1;
			t_warn = 1'b0;
			t_crit = 1'b0;
			red = DUTY_OFF;
			green = DUTY_FULL;
			expected_status.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_TEMP_SAFE_MAX:    th_temp_safe = cfg_wdata[7:0];
					REG_TEMP_WARN_MAX:    th_temp_warn = cfg_wdata[7:0];
					REG_HUM_SAFE_MIN:     th_hum_min = cfg_wdata[7:0];
					REG_HUM_SAFE_MAX:     th_hum_max = cfg_wdata[7:0];
					REG_LIGHT_CRIT_BELOW: th_light_crit = cfg_wdata[11:0];
					REG_LIGHT_WARN_MAX:   th_light_warn = cfg_wdata[11:0];
					REG_SMOKE_WARN_MIN:   th_smoke_warn = cfg_wdata;
					REG_SMOKE_CRIT_ABOVE: th_smoke_crit = cfg_wdata;
					default: ;
				endcase
			end
			if (req_ch.valid && req_ch.ready) begin
				update_alarm_state(req_ch.payload);
				want.alarm_level = alarm_lvl;
				want.buzzer_on = buzz;
				want.red_duty = red;
				want.green_duty = green;
				want.fan_level = t_crit ? FAN_HIGH : (t_warn ? FAN_MEDIUM : FAN_STOP);
				expected_status.push_back(want);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_status.size() == 0) begin
					$error("result with no request outstanding");
					mismatches++;
				end else begin
					want = expected_status.pop_front();
					check_field("alarm_level", 7'(want.alarm_level), 7'(rsp_ch.payload.alarm_level));
					check_field("buzzer_on", 7'(want.buzzer_on), 7'(rsp_ch.payload.buzzer_on));
					check_field("red_duty", want.red_duty, rsp_ch.payload.red_duty);
					check_field("green_duty", want.green_duty, rsp_ch.payload.green_duty);
					check_field("fan_level", 7'(want.fan_level), 7'(rsp_ch.payload.fan_level));
				end
			end
			pending = expected_status.size();
		end
	end

endmodule

>>> sim/environment_alarm_controller_tb.sv
`timescale 1ns / 1ps
// Testbench top for the environment alarm controller: clock, reset, threshold programming,
// request stimulus, result back-pressure and verdict. Depends on eac_pkg, eac_if.sv, the
// controller and alarm_status_checker.
module environment_alarm_controller_tb;
	import eac_pkg::*;

	localparam int BEEP_TOGGLE_TICKS = 10;
	localparam int LED_MIN           = 10;
	localparam int LED_MAX           = 100;
	localparam int STEP_WARN         = 5;
	localparam int STEP_CRIT         = 10;

	localparam int RESET_CYCLES     = 7;
	localparam int SETTLE_CYCLES    = 4;   // margin past the controller's input and result registers
	localparam int TAIL_CYCLES      = 8;
	localparam int HOLD_CYCLES      = 48;  // long receiver stall to back up the pipeline
	localparam int WATCHDOG_LIMIT   = 1000;
	localparam int PHASES           = 8;
	localparam int ITEMS_PER_PHASE  = 190;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = REG_TEMP_SAFE_MAX;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	int fail_count;
	int in_flight;
	int idle_cycles = 0;

	// Flags shared between stimulus and the receiver
	bit quiet = 1'b0;     // no idling on either side
	bit hold_ask = 1'b0;  // request one long receiver stall

	// Threshold mirror, used only to steer readings into chosen bands
	int t_safe = 27, t_warn = 35, h_min = 30, h_max = 70;
	int l_crit = 2000, l_warn = 3000, s_warn = 300, s_crit = 600;

	eac_req_if req_ch ();
	eac_rsp_if rsp_ch ();

	environment_alarm_controller #(
		.BEEP_TOGGLE_TICKS(BEEP_TOGGLE_TICKS),
		.LED_MIN(LED_MIN),
		.LED_MAX(LED_MAX),
		.STEP_WARN(STEP_WARN),
		.STEP_CRIT(STEP_CRIT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	alarm_status_checker #(
		.BEEP_TOGGLE_TICKS(BEEP_TOGGLE_TICKS),
		.LED_MIN(LED_MIN),
		.LED_MAX(LED_MAX),
		.STEP_WARN(STEP_WARN),
		.STEP_CRIT(STEP_CRIT)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata),
		.req_ch(req_ch),
		.rsp_ch(rsp_ch),
		.mismatches(fail_count),
		.pending(in_flight)
	);

	always #6 clk = ~clk;

	// Abort when neither channel moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// Result receiver: mix ready stretches with random stall bursts;
	// honor a single long hold when asked, counting it here.
	initial begin
		bit hold_done;
		int span;
		hold_done = 1'b0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_ask && !hold_done) begin
				rsp_ch.ready = 1'b0;
				hold_done = 1'b1;
				span = HOLD_CYCLES;
			end else if (quiet || $urandom_range(3) != 0) begin
				rsp_ch.ready = 1'b1;
				span = $urandom_range(20, 1);
			end else begin
				rsp_ch.ready = 1'b0;
				span = $urandom_range(7, 1);
			end
			repeat (span) @(negedge clk);
		end
	end

	// Pick a value in [lo, hi], favoring the edges; fall back to the full range when the
	// band is empty under the current thresholds.
	function automatic int pick_in(input int lo, input int hi, input int top);
		if (lo > hi)
			return $urandom_range(top, 0);
		case ($urandom_range(7))
			0:       return lo;
			1:       return hi;
			default: return $urandom_range(hi, lo);
		endcase
	endfunction

	function automatic int gen_temp(input level_t c);
		case (c)
			LVL_SAFE: return pick_in(0, (t_safe < t_warn) ? t_safe : t_warn, 255);
			LVL_WARN: return pick_in(t_safe + 1, t_warn, 255);
			default:  return pick_in(t_warn + 1, 255, 255);
		endcase
	endfunction

	function automatic int gen_hum(input level_t c);
		case (c)
			LVL_SAFE: return pick_in(h_min, h_max, 255);
			LVL_WARN: return pick_in(0, h_min - 1, 255);
			default:  return pick_in(h_max + 1, 255, 255);
		endcase
	endfunction

	function automatic int gen_light(input level_t c);
		case (c)
			LVL_SAFE: return pick_in((l_warn + 1 > l_crit) ? l_warn + 1 : l_crit, 4095, 4095);
			LVL_WARN: return pick_in(l_crit, l_warn, 4095);
			default:  return pick_in(0, l_crit - 1, 4095);
		endcase
	endfunction

	function automatic int gen_smoke(input level_t c);
		case (c)
			LVL_SAFE: return pick_in(0, (s_warn - 1 < s_crit) ? s_warn - 1 : s_crit, 65535);
			LVL_WARN: return pick_in(s_warn, s_crit, 65535);
			default:  return pick_in(s_crit + 1, 65535, 65535);
		endcase
	endfunction

	// Present one request and hold it until the controller takes it.
	task automatic offer_request(input req_t r);
		@(negedge clk);
		req_ch.valid = 1'b1;
		req_ch.payload = r;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	task automatic send_eval(input int t, input int h, input int l, input int s);
		req_t r;
		r.mode = MODE_EVAL;
		r.temperature = 8'(t);
		r.humidity = 8'(h);
		r.light_level = 12'(l);
		r.smoke_ppm = 16'(s);
		offer_request(r);
	endtask

	// LED tick with junk readings; the controller must ignore them.
	task automatic send_tick();
		req_t r;
		r.mode = MODE_LED;
		r.temperature = 8'($urandom);
		r.humidity = 8'($urandom);
		r.light_level = 12'($urandom);
		r.smoke_ppm = 16'($urandom);
		offer_request(r);
	endtask

	// Evaluate request with every reading safe except one pushed into the target band,
	// and now and then a second reading in a random band.
	task automatic send_mixed(input level_t target);
		level_t c[4];
		foreach (c[i]) c[i] = LVL_SAFE;
		c[$urandom_range(3)] = target;
		if ($urandom_range(3) == 0)
			c[$urandom_range(3)] = level_t'($urandom_range(2));
		send_eval(gen_temp(c[0]), gen_hum(c[1]), gen_light(c[2]), gen_smoke(c[3]));
	endtask

	task automatic idle_sender(input int n);
		@(negedge clk);
		req_ch.valid = 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// Drop valid, wait for every result, then give the pipeline time to settle.
	task automatic drain();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (in_flight != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_wdata = data;
		case (idx)
			REG_TEMP_SAFE_MAX:    t_safe = data[7:0];
			REG_TEMP_WARN_MAX:    t_warn = data[7:0];
			REG_HUM_SAFE_MIN:     h_min = data[7:0];
			REG_HUM_SAFE_MAX:     h_max = data[7:0];
			REG_LIGHT_CRIT_BELOW: l_crit = data[11:0];
			REG_LIGHT_WARN_MAX:   l_warn = data[11:0];
			REG_SMOKE_WARN_MIN:   s_warn = data;
			REG_SMOKE_CRIT_ABOVE: s_crit = data;
			default: ;
		endcase
	endtask

	task automatic set_thresholds(input logic [15:0] ts, input logic [15:0] tw,
	                              input logic [15:0] hn, input logic [15:0] hx,
	                              input logic [15:0] lc, input logic [15:0] lw,
	                              input logic [15:0] sw, input logic [15:0] sc);
		write_threshold(REG_TEMP_SAFE_MAX, ts);
		write_threshold(REG_TEMP_WARN_MAX, tw);
		write_threshold(REG_HUM_SAFE_MIN, hn);
		write_threshold(REG_HUM_SAFE_MAX, hx);
		write_threshold(REG_LIGHT_CRIT_BELOW, lc);
		write_threshold(REG_LIGHT_WARN_MAX, lw);
		write_threshold(REG_SMOKE_WARN_MIN, sw);
		write_threshold(REG_SMOKE_CRIT_ABOVE, sc);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		int sent, regime, burst, a, b, c, d;
		bit gappy;

		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// Directed requests at the reset thresholds: a tick while safe, all-zero and
		// all-ones readings, then each reading across both of its band edges.
		send_tick();
		send_eval(0, 0, 0, 0);
		send_tick();
		send_eval(255, 255, 4095, 65535);
		send_tick();
		send_eval(20, 50, 3500, 100);
		send_tick();
		send_eval(27, 50, 3500, 100);
		send_eval(28, 50, 3500, 100);
		send_eval(35, 50, 3500, 100);
		send_eval(36, 50, 3500, 100);
		send_eval(20, 29, 3500, 100);
		send_eval(20, 30, 3500, 100);
		send_eval(20, 70, 3500, 100);
		send_eval(20, 71, 3500, 100);
		send_eval(20, 50, 1999, 100);
		send_eval(20, 50, 2000, 100);
		send_eval(20, 50, 3000, 100);
		send_eval(20, 50, 3001, 100);
		send_eval(20, 50, 3500, 299);
		send_eval(20, 50, 3500, 300);
		send_eval(20, 50, 3500, 600);
		send_eval(20, 50, 3500, 601);
		send_tick();

		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			case (phase)
				// Reset values again, with junk above the width of each temperature, humidity and light register.
				0: set_thresholds(16'hA51B, 16'h5A23, 16'hFF1E, 16'h0146,
				                  16'hF7D0, 16'hABB8, 16'd300, 16'd600);
				1: set_thresholds(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
				2: set_thresholds(16'd255, 16'd255, 16'd255, 16'd255,
				                  16'd4095, 16'd4095, 16'd65535, 16'd65535);
				// Bounds out of order: critical must win over warning.
				3: set_thresholds(16'd200, 16'd50, 16'd200, 16'd20,
				                  16'd3500, 16'd1000, 16'd5000, 16'd100);
				default: begin
					a = $urandom_range(255);
					b = $urandom_range(255);
					c = $urandom_range(4095);
					d = $urandom_range(65535);
					set_thresholds(16'(a), 16'($urandom_range(255, a)),
					               16'(b), 16'($urandom_range(255, b)),
					               16'(c), 16'($urandom_range(4095, c)),
					               16'(d), 16'($urandom_range(65535, d)));
				end
			endcase

			// Run the last phase with no idling on either side.
			if (phase == PHASES - 1)
				quiet = 1'b1;

			// Bursts aimed at one alarm band so the buzzer gets long warning runs and
			// the breathing duty bounces off both limits; a fourth kind is pure noise.
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				regime = $urandom_range(3);
				burst = $urandom_range(40, 4);
				gappy = !quiet && ($urandom_range(1) == 1);
				for (int k = 0; k < burst; k++) begin
					if (gappy && $urandom_range(5) == 0)
						idle_sender($urandom_range(7, 1));
					if ($urandom_range(9) < 4)
						send_tick();
					else if (regime == 3)
						send_eval($urandom_range(255), $urandom_range(255),
						          $urandom_range(4095), $urandom_range(65535));
					else
						send_mixed(level_t'(regime));
					sent++;
					// Stall the receiver once while requests keep coming.
					if (phase == 1 && sent == 60)
						hold_ask = 1'b1;
				end
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
